// ----- hdl/rtb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtb_pkg
// Shared types and codes for the retransmit buffer: command and status codes,
// the stored entry and the per-cell control group.
// ----------------------------------------------------------------------------
package rtb_pkg;

   localparam int DEPTH_DEF  = 32;
   localparam int CMD_W      = 3;
   localparam int SEQ_W      = 8;
   localparam int HANDLE_W   = 16;
   localparam int TIME_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int CNT_OUT_W  = 6;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_NACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ACK    = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [SEQ_W-1:0]    seq_number;
      logic [HANDLE_W-1:0] packet_handle;
      logic [TIME_W-1:0]   send_time;
   } rtb_entry_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic clear;
   } rtb_cell_ctrl_type;

endpackage

// ----- hdl/rtb_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtb_cell
// One queue position: holds an entry, takes its neighbor's entry on a shift,
// takes the pushed entry on a load and compares its sequence number.
// ----------------------------------------------------------------------------
module rtb_cell (
   input  logic                       clock,
   input  rtb_pkg::rtb_cell_ctrl_type ctrl,
   input  rtb_pkg::rtb_entry_type     push_entry,
   input  rtb_pkg::rtb_entry_type     neighbor_entry,
   input  logic [7:0]                 key,
   output rtb_pkg::rtb_entry_type     entry,
   output logic                       match
);
   import rtb_pkg::*;

   rtb_entry_type entry_ff;
   rtb_entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         entry_in = push_entry;
      end else if (ctrl.shift) begin
         entry_in = neighbor_entry;
      end else if (ctrl.clear) begin
         entry_in.send_time = '0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff.seq_number == key);

endmodule

// ----- hdl/rtb_pick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtb_pick
// Oldest-match picker: isolates the lowest set bit of the match vector and
// selects that cell's entry.
// ----------------------------------------------------------------------------
module rtb_pick #(
   parameter int DEPTH = rtb_pkg::DEPTH_DEF
) (
   input  logic [DEPTH-1:0]       match_vec,
   input  rtb_pkg::rtb_entry_type entries [DEPTH],
   output logic [DEPTH-1:0]       hit_onehot,
   output logic                   found,
   output rtb_pkg::rtb_entry_type sel_entry
);
   import rtb_pkg::*;

   assign hit_onehot = match_vec & (~match_vec + DEPTH'(1));
   assign found      = |match_vec;

   always_comb begin
      sel_entry = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_entry = sel_entry | (entries[i] & {$bits(rtb_entry_type){hit_onehot[i]}});
      end
   end

endmodule

// ----- hdl/retransmit_buffer_with_cumulative_ack_core.sv -----
`timescale 1ns / 1ps
// Sequence: push, pop and unused codes finish in exec; lookups go on to pick;
//   cumulative delete goes on to the delete walk, removing 1 to DEPTH entries.
// Throughput: one item at a time, a new request only in idle; delete walks the
//   cell chain one shift per cycle, holding the last shift while a result waits.
// Reset: synchronous; empties the queue and clears the response valid flag;
//   entries and the result register are not cleared.
// ----------------------------------------------------------------------------
// retransmit_buffer_with_cumulative_ack_core
// Sender retransmission queue built as a shifting row of cells, oldest entry in
// cell 0, with push, pop, cumulative delete and nack/ack lookup.
// ----------------------------------------------------------------------------
module retransmit_buffer_with_cumulative_ack_core #(
   parameter int DEPTH = rtb_pkg::DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rtb_pkg::CMD_W-1:0]        req_command,
   input  logic [rtb_pkg::SEQ_W-1:0]        req_seq_number,
   input  logic [rtb_pkg::HANDLE_W-1:0]     req_packet_handle,
   input  logic [rtb_pkg::TIME_W-1:0]       req_send_time,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rtb_pkg::STATUS_W-1:0]     rsp_status,
   output logic [rtb_pkg::HANDLE_W-1:0]     rsp_out_handle,
   output logic [rtb_pkg::SEQ_W-1:0]        rsp_out_seq,
   output logic [rtb_pkg::TIME_W-1:0]       rsp_out_time,
   output logic [rtb_pkg::CNT_OUT_W-1:0]    rsp_removed_count,
   output logic [rtb_pkg::CNT_OUT_W-1:0]    rsp_occupancy
);
   import rtb_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_PICK   = 4'b0100,
      ST_DELETE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        removed_ff, removed_in;
   logic [DEPTH-1:0]     match_ff, match_in;
   logic [CMD_W-1:0]     cmd_ff;
   logic [SEQ_W-1:0]     key_ff;
   rtb_entry_type        push_ff;

   rtb_entry_type        cell_entry [DEPTH];
   logic [DEPTH-1:0]     cell_match;
   logic [DEPTH-1:0]     occ_vec;
   rtb_cell_ctrl_type    cell_ctrl [DEPTH];
   logic [DEPTH-1:0]     hit_onehot;
   logic                 found;
   rtb_entry_type        sel_entry;

   logic                 shift, push_go, clear_go, commit, fin_ok, empty, last;
   logic [STATUS_W-1:0]  res_status;
   rtb_entry_type        res_entry;
   logic [CW-1:0]        res_removed;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff;
   rtb_entry_type        out_entry_ff;
   logic [CNT_OUT_W-1:0] removed_out_ff, occ_out_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign fin_ok    = !rsp_valid_ff || rsp_ready;
   assign empty     = (count_ff == '0);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occ_vec[i]         = (count_ff > CW'(i));
      assign cell_ctrl[i].shift = shift;
      assign cell_ctrl[i].load  = push_go && (count_ff == CW'(i));
      assign cell_ctrl[i].clear = clear_go && hit_onehot[i];

      rtb_cell u_cell (
         .clock          (clock),
         .ctrl           (cell_ctrl[i]),
         .push_entry     (push_ff),
         .neighbor_entry (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
         .key            (key_ff),
         .entry          (cell_entry[i]),
         .match          (cell_match[i])
      );
   end

   rtb_pick #(.DEPTH(DEPTH)) u_pick (
      .match_vec  (match_ff),
      .entries    (cell_entry),
      .hit_onehot (hit_onehot),
      .found      (found),
      .sel_entry  (sel_entry)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      removed_in  = removed_ff;
      match_in    = match_ff;
      shift       = 1'b0;
      push_go     = 1'b0;
      clear_go    = 1'b0;
      commit      = 1'b0;
      last        = 1'b0;
      res_status  = STAT_OK;
      res_entry   = '0;
      res_removed = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (cmd_ff)
               CMD_PUSH: begin
                  if (fin_ok) begin
                     commit   = 1'b1;
                     state_in = ST_IDLE;
                     if (count_ff == CW'(DEPTH)) begin
                        res_status = STAT_FULL;
                     end else begin
                        push_go  = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
               end
               CMD_POP: begin
                  if (fin_ok) begin
                     commit   = 1'b1;
                     state_in = ST_IDLE;
                     if (empty) begin
                        res_status = STAT_EMPTY;
                     end else begin
                        res_entry = cell_entry[0];
                        shift     = 1'b1;
                        count_in  = count_ff - CW'(1);
                     end
                  end
               end
               CMD_DELETE, CMD_NACK, CMD_ACK: begin
                  if (empty) begin
                     if (fin_ok) begin
                        commit     = 1'b1;
                        state_in   = ST_IDLE;
                        res_status = STAT_EMPTY;
                     end
                  end else if (cmd_ff == CMD_DELETE) begin
                     removed_in = '0;
                     state_in   = ST_DELETE;
                  end else begin
                     match_in = cell_match & occ_vec;
                     state_in = ST_PICK;
                  end
               end
               default: begin
                  if (fin_ok) begin
                     commit   = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_PICK: begin
            if (fin_ok) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
               if (!found) begin
                  res_status = STAT_NOTFOUND;
               end else begin
                  res_entry = sel_entry;
                  if (cmd_ff == CMD_NACK) begin
                     res_entry.send_time = '0;
                     clear_go            = 1'b1;
                  end
               end
            end
         end
         ST_DELETE: begin
            last = cell_match[0] || (count_ff == CW'(1));
            if (!last || fin_ok) begin
               shift      = 1'b1;
               count_in   = count_ff - CW'(1);
               removed_in = removed_ff + CW'(1);
               if (last) begin
                  commit      = 1'b1;
                  state_in    = ST_IDLE;
                  res_status  = cell_match[0] ? STAT_OK : STAT_NOTFOUND;
                  res_removed = removed_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff <= removed_in;
      match_ff   <= match_in;
      if (req_valid && req_ready) begin
         cmd_ff                 <= req_command;
         key_ff                 <= req_seq_number;
         push_ff.seq_number     <= req_seq_number;
         push_ff.packet_handle  <= req_packet_handle;
         push_ff.send_time      <= req_send_time;
      end
      if (commit) begin
         status_ff      <= res_status;
         out_entry_ff   <= res_entry;
         removed_out_ff <= CNT_OUT_W'(res_removed);
         occ_out_ff     <= CNT_OUT_W'(count_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_handle    = out_entry_ff.packet_handle;
   assign rsp_out_seq       = out_entry_ff.seq_number;
   assign rsp_out_time      = out_entry_ff.send_time;
   assign rsp_removed_count = removed_out_ff;
   assign rsp_occupancy     = occ_out_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while one is in work");

   a_idle_holds_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("entry count moved while idle");

   a_delete_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELETE) |-> (count_ff != '0))
      else $error("delete walk on an empty queue");
`endif

endmodule
